@@ design/mm4_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mm4_pkg - shared types and constants for the 4x4 matrix multiplier
// Matrix size, fixed-point format and the link word between chain cells.
// ----------------------------------------------------------------------------
package mm4_pkg;

  localparam int Dim       = 4;
  localparam int Cells     = Dim * Dim;
  localparam int FracBits  = 16;
  localparam int DataW     = 32;
  localparam int PosW      = $clog2(Cells);
  localparam int SelW      = $clog2(Dim);
  localparam int ProdW     = 2 * DataW;
  localparam int AccW      = ProdW + $clog2(Dim);

  localparam logic [PosW-1:0] LastPos = PosW'(Cells - 1);

  typedef struct packed {
    logic                   valid;
    logic [PosW-1:0]        idx;
    logic signed [AccW-1:0] acc;
  } mm4_link_t;

endpackage
`default_nettype wire

@@ design/matrix_multiply_4x4.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// matrix_multiply_4x4 - fixed-point 4x4 matrix product
// A load word writes one element into the cell stores. A compute word issues
// 16 dot products into a chain of four multiply-accumulate cells, each cell
// with registers s1 and s2; results then leave one per cycle while res_stall
// is low. New words are held off from a compute word until its last result is taken.
// Synchronous reset clears control state; the matrix stores are undefined.
// ----------------------------------------------------------------------------
module matrix_multiply_4x4 (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              src_valid,
  output logic                              src_stall,
  input  logic                              operand_side,
  input  logic [3:0]                        position,
  input  logic signed [31:0]                element_value,
  input  logic                              compute_now,
  output logic                              res_valid,
  input  logic                              res_stall,
  output logic signed [31:0]                product_value,
  output logic [3:0]                        product_position,
  output logic                              last_of_run
);
  import mm4_pkg::*;

  localparam int ShW = AccW - FracBits;

  logic            busy;
  logic            issuing;
  logic [PosW-1:0] cnt;
  logic            en;
  logic            accept;
  mm4_link_t       link [Dim+1];
  logic signed [ShW-1:0] shifted;
  logic signed [DataW-1:0] sat;
  logic            res_take;

  assign en       = !res_valid || !res_stall;
  assign src_stall = busy;
  assign accept   = src_valid && !busy;
  assign res_take = res_valid && !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      issuing <= 1'b0;
      cnt     <= '0;
    end else begin
      if (accept && compute_now) begin
        busy    <= 1'b1;
        issuing <= 1'b1;
        cnt     <= '0;
      end else if (en && issuing) begin
        cnt <= cnt + PosW'(1);
        if (cnt == LastPos) begin
          issuing <= 1'b0;
        end
      end
      if (res_take && last_of_run) begin
        busy <= 1'b0;
      end
    end
  end

  assign link[0].valid = issuing;
  assign link[0].idx   = cnt;
  assign link[0].acc   = '0;

  for (genvar k = 0; k < Dim; k++) begin : g_cell
    mm4_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .wr_left  (accept && !operand_side && position[PosW-1:SelW] == SelW'(k)),
      .wr_right (accept && operand_side && position[SelW-1:0] == SelW'(k)),
      .wr_addr  (operand_side ? position[PosW-1:SelW] : position[SelW-1:0]),
      .wr_data  (element_value),
      .link_in  (link[k]),
      .link_out (link[k+1])
    );
  end

  always_comb begin
    shifted = ShW'(link[Dim].acc >>> FracBits);
    if (shifted > ShW'(signed'({1'b0, {(DataW-1){1'b1}}}))) begin
      sat = {1'b0, {(DataW-1){1'b1}}};
    end else if (shifted < -(ShW'(1) <<< (DataW-1))) begin
      sat = {1'b1, {(DataW-1){1'b0}}};
    end else begin
      sat = shifted[DataW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en) begin
      res_valid <= link[Dim].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      product_value    <= sat;
      product_position <= link[Dim].idx;
      last_of_run      <= link[Dim].idx == LastPos;
    end
  end

  a_busy_stall : assert property (@(posedge clk) disable iff (rst)
    issuing |-> src_stall)
    else $error("word accepted while products are issued");
  a_hold : assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> $stable(product_value) && $stable(product_position))
    else $error("stalled result changed");
  a_last : assert property (@(posedge clk) disable iff (rst)
    res_take && last_of_run |=> !busy && !issuing)
    else $error("run did not finish after its last result");
  a_idle_out : assert property (@(posedge clk) disable iff (rst)
    !busy |-> !res_valid)
    else $error("result outside a run");

endmodule
`default_nettype wire

@@ design/mm4_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mm4_cell - one multiply-accumulate cell of the chain
// Holds one column of the left matrix and one row of the right matrix,
// multiplies the pair selected by the passing index and adds to the sum.
// ----------------------------------------------------------------------------
module mm4_cell (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            wr_left,
  input  logic                            wr_right,
  input  logic [mm4_pkg::SelW-1:0]        wr_addr,
  input  logic signed [mm4_pkg::DataW-1:0] wr_data,
  input  mm4_pkg::mm4_link_t              link_in,
  output mm4_pkg::mm4_link_t              link_out
);
  import mm4_pkg::*;

  logic signed [DataW-1:0] left_col  [Dim];
  logic signed [DataW-1:0] right_row [Dim];

  logic                    s1_valid;
  logic [PosW-1:0]         s1_idx;
  logic signed [AccW-1:0]  s1_acc;
  logic signed [ProdW-1:0] s1_prod;
  logic                    s2_valid;
  logic [PosW-1:0]         s2_idx;
  logic signed [AccW-1:0]  s2_acc;

  always_ff @(posedge clk) begin
    if (wr_left) begin
      left_col[wr_addr] <= wr_data;
    end
    if (wr_right) begin
      right_row[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= link_in.valid;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_idx  <= link_in.idx;
      s1_acc  <= link_in.acc;
      s1_prod <= ProdW'(left_col[link_in.idx[SelW-1:0]]) *
                 ProdW'(right_row[link_in.idx[PosW-1:SelW]]);
      s2_idx  <= s1_idx;
      s2_acc  <= s1_acc + AccW'(s1_prod);
    end
  end

  assign link_out.valid = s2_valid;
  assign link_out.idx   = s2_idx;
  assign link_out.acc   = s2_acc;

endmodule
`default_nettype wire
